[design/sorted_priority_queue_assert.svh]
// Assertion macros for the sorted priority queue checker.
// Depends on nothing; included by the checker file only.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");

`endif

[design/spq_pkg.sv]
// Shared types for the sorted priority queue: operation codes and control structs.
// No dependencies.
package spq_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PEEK   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		logic ok;
		logic is_empty;
		logic is_full;
	} flags_t;

	// top -> sequencer
	typedef struct packed {
		logic start;
		logic take;
		op_t  op;
	} cmd_t;

	// sequencer -> top
	typedef struct packed {
		logic   idle;
		logic   done;
		flags_t flags;
	} stat_t;

endpackage

[design/spq_if.sv]
// Valid/ready channel interfaces for the sorted priority queue request and response.
// No dependencies.
interface spq_req_if #(
	parameter int DATA_WIDTH = 32,
	parameter int PRIO_WIDTH = 16
) ();
	logic                         valid;
	logic                         ready;
	logic [1:0]                   operation;
	logic [DATA_WIDTH-1:0]        item_data;
	logic signed [PRIO_WIDTH-1:0] item_priority;

	modport source (output valid, output operation, output item_data, output item_priority,
		input ready);
	modport sink (input valid, input operation, input item_data, input item_priority,
		output ready);
endinterface

interface spq_rsp_if #(
	parameter int DATA_WIDTH = 32,
	parameter int PRIO_WIDTH = 16
) ();
	logic                         valid;
	logic                         ready;
	logic [DATA_WIDTH-1:0]        out_data;
	logic signed [PRIO_WIDTH-1:0] out_priority;
	logic                         ok;
	logic                         is_empty;
	logic                         is_full;

	modport source (output valid, output out_data, output out_priority, output ok,
		output is_empty, output is_full, input ready);
	modport sink (input valid, input out_data, input out_priority, input ok,
		input is_empty, input is_full, output ready);
endinterface

[design/spq_mem.sv]
// Entry store: one write port, one read port with registered read data.
// No dependencies.
module spq_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/spq_ctrl.sv]
// Sequencer for the sorted priority queue: walks the entry store one entry per
// cycle with a single priority comparator. Depends on spq_pkg and spq_mem.
module spq_ctrl #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PRIO_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spq_pkg::cmd_t                cmd,
	input  logic [DATA_WIDTH-1:0]        item_data,
	input  logic signed [PRIO_WIDTH-1:0] item_priority,
	output spq_pkg::stat_t               stat,
	output logic [DATA_WIDTH-1:0]        res_data,
	output logic signed [PRIO_WIDTH-1:0] res_priority
);
	import spq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = DATA_WIDTH + PRIO_WIDTH;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [AW-1:0] ONE_A = AW'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_PUT,
		S_HEAD,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                       state_q;
	op_t                          op_q;
	logic [CW-1:0]                cnt_q;
	logic [AW-1:0]                ptr_q;
	logic [DATA_WIDTH-1:0]        data_q;
	logic signed [PRIO_WIDTH-1:0] prio_q;
	logic                         ok_q;
	logic [DATA_WIDTH-1:0]        res_data_q;
	logic signed [PRIO_WIDTH-1:0] res_prio_q;

	logic                         we;
	logic [AW-1:0]                waddr;
	logic [EW-1:0]                wdata;
	logic [AW-1:0]                raddr;
	logic [EW-1:0]                rdata;
	logic [DATA_WIDTH-1:0]        rd_data;
	logic signed [PRIO_WIDTH-1:0] rd_prio;
	logic                         rd_lower;
	logic [CW-1:0]                cnt_dec;
	logic [CW-1:0]                ptr_ext;

	spq_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(EW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_data  = rdata[DATA_WIDTH-1:0];
	assign rd_prio  = rdata[EW-1:DATA_WIDTH];
	assign rd_lower = rd_prio < prio_q;  // the shared comparator
	assign cnt_dec  = cnt_q - ONE_C;
	assign ptr_ext  = CW'(ptr_q);

	// store port control
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = {prio_q, data_q};
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd.start && cmd.op == OP_INSERT) begin
					if (cnt_q == '0) begin
						we    = 1'b1;
						waddr = '0;
						wdata = {item_priority, item_data};
					end else begin
						raddr = cnt_dec[AW-1:0];  // tail entry
					end
				end
			end
			S_INS_CMP: begin
				we = 1'b1;
				if (rd_lower) begin
					wdata = rdata;
					raddr = ptr_q - ONE_A - ONE_A;
				end
			end
			S_INS_PUT: begin
				we = 1'b1;
			end
			S_HEAD: begin
				raddr = ONE_A;
			end
			S_SHIFT: begin
				we    = 1'b1;
				waddr = ptr_q - ONE_A;
				wdata = rdata;
				raddr = ptr_q + ONE_A;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ok_q    <= 1'b0;
			op_q    <= OP_INSERT;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						op_q       <= cmd.op;
						data_q     <= item_data;
						prio_q     <= item_priority;
						res_data_q <= '0;
						res_prio_q <= '0;
						ok_q       <= 1'b0;
						case (cmd.op)
							OP_INSERT: begin
								if (cnt_q == CAP_C) begin
									state_q <= S_DONE;
								end else if (cnt_q == '0) begin
									cnt_q   <= cnt_q + ONE_C;
									ok_q    <= 1'b1;
									state_q <= S_DONE;
								end else begin
									ptr_q   <= cnt_q[AW-1:0];
									state_q <= S_INS_CMP;
								end
							end
							OP_REMOVE, OP_PEEK: begin
								if (cnt_q == '0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_HEAD;
								end
							end
							default: begin
								cnt_q   <= '0;
								ok_q    <= 1'b1;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS_CMP: begin
					if (rd_lower) begin
						ptr_q <= ptr_q - ONE_A;
						if (ptr_q == ONE_A) begin
							state_q <= S_INS_PUT;
						end
					end else begin
						cnt_q   <= cnt_q + ONE_C;
						ok_q    <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_INS_PUT: begin
					cnt_q   <= cnt_q + ONE_C;
					ok_q    <= 1'b1;
					state_q <= S_DONE;
				end
				S_HEAD: begin
					res_data_q <= rd_data;
					res_prio_q <= rd_prio;
					ok_q       <= 1'b1;
					if (op_q == OP_PEEK) begin
						state_q <= S_DONE;
					end else if (cnt_q == ONE_C) begin
						cnt_q   <= cnt_dec;
						state_q <= S_DONE;
					end else begin
						ptr_q   <= ONE_A;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (ptr_ext == cnt_dec) begin
						cnt_q   <= cnt_dec;
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + ONE_A;
					end
				end
				S_DONE: begin
					if (cmd.take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle           = (state_q == S_IDLE);
	assign stat.done           = (state_q == S_DONE);
	assign stat.flags.ok       = ok_q;
	assign stat.flags.is_empty = (cnt_q == '0);
	assign stat.flags.is_full  = (cnt_q == CAP_C);
	assign res_data            = res_data_q;
	assign res_priority        = res_prio_q;
endmodule

[design/sorted_priority_queue.sv]
// Sorted priority queue of CAPACITY entries, highest priority at the head and equal
// priorities served first in, first out. One operation is handled at a time; request
// ready is high only while the sequencer is idle, and the response sits in an output
// register so the next request can be taken while the last response waits. Clear, a full
// insert, an empty remove/peek and an insert into an empty queue go straight to the
// response; peek reads the head; an insert moves each lower-priority entry one place
// toward the tail; a remove reads the head and, with two or more entries, shifts the
// rest one place toward the head. The entry store (one write port, one registered read
// port) is walked one entry per cycle by one priority comparator.
// Depends on spq_pkg, spq_if, spq_ctrl, spq_mem.
module sorted_priority_queue #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PRIO_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   request,
	spq_rsp_if.source response
);
	import spq_pkg::*;

	cmd_t                         cmd;
	stat_t                        stat;
	logic [DATA_WIDTH-1:0]        res_data;
	logic signed [PRIO_WIDTH-1:0] res_priority;

	// response register
	logic                         out_valid_q;
	logic [DATA_WIDTH-1:0]        out_data_q;
	logic signed [PRIO_WIDTH-1:0] out_prio_q;
	flags_t                       out_flags_q;

	// a request transfers only while the sequencer is idle
	assign request.ready = stat.idle;
	assign cmd.start     = request.valid && stat.idle;
	assign cmd.op        = op_t'(request.operation);
	// finished result moves into the response register once it is free or draining
	assign cmd.take      = stat.done && (!out_valid_q || response.ready);

	spq_ctrl #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH),
		.PRIO_WIDTH(PRIO_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item_data    (request.item_data),
		.item_priority(request.item_priority),
		.stat         (stat),
		.res_data     (res_data),
		.res_priority (res_priority)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.take) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			out_data_q  <= res_data;
			out_prio_q  <= res_priority;
			out_flags_q <= stat.flags;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.out_data     = out_data_q;
	assign response.out_priority = out_prio_q;
	assign response.ok           = out_flags_q.ok;
	assign response.is_empty     = out_flags_q.is_empty;
	assign response.is_full      = out_flags_q.is_full;
endmodule

[design/spq_checker.sv]
// Port-level checks for sorted_priority_queue, attached by bind.
// Depends on spq_if and sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"

module spq_checker (
	input logic     clk,
	input logic     arst_n,
	spq_req_if.sink   request,
	spq_rsp_if.source response
);
	// one operation at a time: busy right after a request transfer
	`SPQ_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, request.valid && request.ready, !request.ready)

	// with a nonzero capacity, both flags never hold together
	`SPQ_ASSERT_NOW(a_flags_exclusive, clk, arst_n, response.valid, !(response.is_empty && response.is_full))

	// a failed operation carries no head
	`SPQ_ASSERT_NOW(a_fail_zero, clk, arst_n, response.valid && !response.ok, response.out_data == '0 && response.out_priority == '0)

	// stalled response holds
	`SPQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, response.valid && !response.ready, response.valid && $stable(response.out_data) && $stable(response.ok))
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.request (request),
	.response(response)
);
